// File: design/esv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esv_pkg: shared types and constants for the ElGamal sign/verify engine
// Command/status structs between controller and datapath, register indexes,
// and register reset values.
// ----------------------------------------------------------------------------
package esv_pkg;

    localparam int WIDTH_DEF = 31;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_KEY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_KEY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE       = 3'd4;

    // register reset values
    localparam longint RST_MODULUS     = 2039;
    localparam longint RST_GENERATOR   = 5;
    localparam longint RST_PRIVATE_KEY = 3;
    localparam longint RST_PUBLIC_KEY  = 125;
    localparam longint RST_NONCE       = 35;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_LD_GK,
        OP_LD_GM,
        OP_LD_HR,
        OP_LD_RS,
        OP_RED_B,
        OP_MUL_ACC,
        OP_SQR,
        OP_SAVE_R,
        OP_SAVE_LHS,
        OP_SAVE_RHS,
        OP_MUL_FIN,
        OP_LD_EU,
        OP_RED_R1,
        OP_DIV,
        OP_QT,
        OP_RED_D,
        OP_MUL_DR,
        OP_RED_M,
        OP_SUB,
        OP_MUL_S
    } op_t;

    // result kinds
    typedef enum logic [1:0] {
        RES_SIGN,
        RES_NOINV,
        RES_BADP,
        RES_VER
    } res_t;

    typedef struct packed {
        logic take;
        logic exec;
        op_t  op;
        logic finish;
        res_t res;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic kind;
        logic p_small;
        logic exp_zero;
        logic exp_lsb;
        logic r1_zero;
        logic r0_one;
        logic out_free;
    } stat_t;

    // ops that run the shared modular multiply/divide unit
    function automatic logic is_unit_op(input op_t op);
        logic u;
        case (op)
            OP_RED_B, OP_MUL_ACC, OP_SQR, OP_MUL_FIN, OP_RED_R1, OP_DIV,
            OP_QT, OP_RED_D, OP_MUL_DR, OP_RED_M, OP_MUL_S: u = 1'b1;
            default: u = 1'b0;
        endcase
        return u;
    endfunction

endpackage

// File: design/esv_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esv_dpath: datapath of the ElGamal engine
// Config registers, operand registers, a bit-serial modular multiply/divide
// unit (one operand bit per cycle) and the output register.
// ----------------------------------------------------------------------------
module esv_dpath
    import esv_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]     cfg_data,
    input  logic                 kind,
    input  logic [WIDTH-1:0]     message,
    input  logic [WIDTH-1:0]     check_r,
    input  logic [WIDTH-1:0]     check_s,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [WIDTH-1:0]     sig_r,
    output logic [WIDTH-1:0]     sig_s,
    output logic                 verified,
    output logic                 no_inverse,
    input  cmd_t                 cmd,
    output stat_t                stat
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);
    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

    // config
    logic [WIDTH-1:0] modulus_reg, generator_reg, private_key_reg;
    logic [WIDTH-1:0] public_key_reg, nonce_reg;
    logic [WIDTH-1:0] nsub;

    // item
    logic             kind_reg;
    logic [WIDTH-1:0] message_reg, check_r_reg, check_s_reg;

    // working registers
    logic [WIDTH-1:0] base_reg, exp_reg, pacc_reg;
    logic [WIDTH-1:0] r0_reg, r1_reg, t0_reg, t1_reg, q_reg;
    logic [WIDTH-1:0] lhs_reg, rhs_reg, sr_reg;

    // serial unit
    logic             busy_reg, done_reg;
    logic [CW-1:0]    cnt_reg;
    op_t              uop_reg;
    logic [WIDTH-1:0] ua_reg, ub_reg, un_reg, uacc_reg, uq_reg;
    logic [WIDTH-1:0] ua_sel, ub_sel, un_sel;
    logic [WIDTH:0]   dbl, dbl_red, sum, sum_red;
    logic             qbit;
    logic [WIDTH-1:0] ures, uquot;
    logic [WIDTH:0]   t_diff, m_diff;

    // output
    logic             out_valid_reg, verified_reg, no_inverse_reg;
    logic [WIDTH-1:0] sig_r_reg, sig_s_reg;

    assign nsub = modulus_reg - ONE;

    // one step: acc = (2*acc + abit*b) mod n, quotient bit when a subtract hits
    assign dbl     = {uacc_reg, 1'b0};
    assign dbl_red = (dbl >= {1'b0, un_reg}) ? dbl - {1'b0, un_reg} : dbl;
    assign sum     = dbl_red + (ua_reg[WIDTH-1] ? {1'b0, ub_reg} : '0);
    assign sum_red = (sum >= {1'b0, un_reg}) ? sum - {1'b0, un_reg} : sum;
    assign qbit    = (dbl >= {1'b0, un_reg}) | (sum >= {1'b0, un_reg});
    assign ures    = sum_red[WIDTH-1:0];
    assign uquot   = {uq_reg[WIDTH-2:0], qbit};

    // modular subtracts for the Euclid update and for m - d*r
    assign t_diff = (t0_reg >= ures) ? {1'b0, t0_reg} - {1'b0, ures}
                                     : {1'b0, t0_reg} + {1'b0, nsub} - {1'b0, ures};
    assign m_diff = (rhs_reg >= lhs_reg) ? {1'b0, rhs_reg} - {1'b0, lhs_reg}
                                         : {1'b0, rhs_reg} + {1'b0, nsub} - {1'b0, lhs_reg};

    // unit operand selection
    always_comb
    begin
        ua_sel = base_reg;
        ub_sel = ONE;
        un_sel = modulus_reg;
        case (cmd.op)
            OP_RED_B:   begin ua_sel = base_reg;    ub_sel = ONE;      un_sel = modulus_reg; end
            OP_MUL_ACC: begin ua_sel = pacc_reg;    ub_sel = base_reg; un_sel = modulus_reg; end
            OP_SQR:     begin ua_sel = base_reg;    ub_sel = base_reg; un_sel = modulus_reg; end
            OP_MUL_FIN: begin ua_sel = pacc_reg;    ub_sel = rhs_reg;  un_sel = modulus_reg; end
            OP_RED_R1:  begin ua_sel = nonce_reg;   ub_sel = ONE;      un_sel = nsub;        end
            OP_DIV:     begin ua_sel = r0_reg;      ub_sel = ONE;      un_sel = r1_reg;      end
            OP_QT:      begin ua_sel = q_reg;       ub_sel = t1_reg;   un_sel = nsub;        end
            OP_RED_D:   begin ua_sel = private_key_reg; ub_sel = ONE;  un_sel = nsub;        end
            OP_MUL_DR:  begin ua_sel = sr_reg;      ub_sel = lhs_reg;  un_sel = nsub;        end
            OP_RED_M:   begin ua_sel = message_reg; ub_sel = ONE;      un_sel = nsub;        end
            OP_MUL_S:   begin ua_sel = rhs_reg;     ub_sel = t0_reg;   un_sel = nsub;        end
            default:    begin ua_sel = base_reg;    ub_sel = ONE;      un_sel = modulus_reg; end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= WIDTH'(RST_MODULUS);
            generator_reg   <= WIDTH'(RST_GENERATOR);
            private_key_reg <= WIDTH'(RST_PRIVATE_KEY);
            public_key_reg  <= WIDTH'(RST_PUBLIC_KEY);
            nonce_reg       <= WIDTH'(RST_NONCE);
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MODULUS:     modulus_reg     <= cfg_data;
                    CFG_GENERATOR:   generator_reg   <= cfg_data;
                    CFG_PRIVATE_KEY: private_key_reg <= cfg_data;
                    CFG_PUBLIC_KEY:  public_key_reg  <= cfg_data;
                    CFG_NONCE:       nonce_reg       <= cfg_data;
                    default: ;
                endcase
            end

            done_reg <= 1'b0;
            if (cmd.exec)
            begin
                if (is_unit_op(cmd.op))
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CW'(1);
            end

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            kind_reg    <= kind;
            message_reg <= message;
            check_r_reg <= check_r;
            check_s_reg <= check_s;
        end

        if (cmd.exec)
        begin
            case (cmd.op)
                OP_LD_GK:    begin base_reg <= generator_reg; exp_reg <= nonce_reg;
                                   pacc_reg <= ONE; end
                OP_LD_GM:    begin base_reg <= generator_reg; exp_reg <= message_reg;
                                   pacc_reg <= ONE; end
                OP_LD_HR:    begin base_reg <= public_key_reg; exp_reg <= check_r_reg;
                                   pacc_reg <= ONE; end
                OP_LD_RS:    begin base_reg <= check_r_reg; exp_reg <= check_s_reg;
                                   pacc_reg <= ONE; end
                OP_SAVE_R:   sr_reg  <= pacc_reg;
                OP_SAVE_LHS: lhs_reg <= pacc_reg;
                OP_SAVE_RHS: rhs_reg <= pacc_reg;
                OP_LD_EU:    begin r0_reg <= nsub; r1_reg <= nonce_reg;
                                   t0_reg <= '0; t1_reg <= ONE; end
                OP_SUB:      rhs_reg <= m_diff[WIDTH-1:0];
                default:
                begin
                    ua_reg   <= ua_sel;
                    ub_reg   <= ub_sel;
                    un_reg   <= un_sel;
                    uacc_reg <= '0;
                    uq_reg   <= '0;
                    uop_reg  <= cmd.op;
                end
            endcase
        end
        else if (busy_reg)
        begin
            ua_reg   <= {ua_reg[WIDTH-2:0], 1'b0};
            uacc_reg <= ures;
            uq_reg   <= uquot;
            // write back on the last bit
            if (cnt_reg == LAST)
            begin
                case (uop_reg)
                    OP_RED_B:   base_reg <= ures;
                    OP_MUL_ACC: pacc_reg <= ures;
                    OP_SQR:     begin base_reg <= ures; exp_reg <= exp_reg >> 1; end
                    OP_MUL_FIN: rhs_reg <= ures;
                    OP_RED_R1:  r1_reg <= ures;
                    OP_DIV:     begin r0_reg <= r1_reg; r1_reg <= ures; q_reg <= uquot; end
                    OP_QT:      begin t0_reg <= t1_reg; t1_reg <= t_diff[WIDTH-1:0]; end
                    OP_RED_D:   lhs_reg <= ures;
                    OP_MUL_DR:  lhs_reg <= ures;
                    OP_RED_M:   rhs_reg <= ures;
                    // s stays in a working register until the result is loaded
                    OP_MUL_S:   rhs_reg <= ures;
                    default: ;
                endcase
            end
        end

        // result register
        if (cmd.finish)
        begin
            case (cmd.res)
                RES_SIGN:
                begin
                    sig_r_reg <= sr_reg; sig_s_reg <= rhs_reg;
                    verified_reg <= 1'b0; no_inverse_reg <= 1'b0;
                end
                RES_NOINV:
                begin
                    sig_r_reg <= sr_reg; sig_s_reg <= '0;
                    verified_reg <= 1'b0; no_inverse_reg <= 1'b1;
                end
                RES_VER:
                begin
                    sig_r_reg <= '0; sig_s_reg <= '0;
                    verified_reg <= (lhs_reg == rhs_reg); no_inverse_reg <= 1'b0;
                end
                default:
                begin
                    sig_r_reg <= '0; sig_s_reg <= '0;
                    verified_reg <= 1'b0; no_inverse_reg <= ~kind_reg;
                end
            endcase
        end
    end

    // status to the controller
    always_comb
    begin
        stat.done     = done_reg;
        stat.kind     = kind_reg;
        stat.p_small  = (modulus_reg < WIDTH'(3));
        stat.exp_zero = (exp_reg == '0);
        stat.exp_lsb  = exp_reg[0];
        stat.r1_zero  = (r1_reg == '0);
        stat.r0_one   = (r0_reg == ONE);
        stat.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign sig_r      = sig_r_reg;
    assign sig_s      = sig_s_reg;
    assign verified   = verified_reg;
    assign no_inverse = no_inverse_reg;

endmodule

// File: design/esv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esv_ctrl: sequencer of the ElGamal engine
// Steps the datapath through exponentiations, the extended Euclid loop and
// the final sign/verify arithmetic, one micro-operation at a time.
// ----------------------------------------------------------------------------
module esv_ctrl
    import esv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    op_t    step_reg, step_next;
    op_t    pow_reg, pow_next;
    res_t   res_reg, res_next;

    // next step after the current one completes
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pow_next   = pow_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (stat.p_small)
                begin
                    res_next   = RES_BADP;
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next  = stat.kind ? OP_LD_GM : OP_LD_GK;
                    pow_next   = step_next;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ST_ISSUE;
                    case (step_reg)
                        OP_LD_GK, OP_LD_GM, OP_LD_HR, OP_LD_RS:
                            step_next = OP_RED_B;
                        OP_RED_B, OP_SQR:
                        begin
                            // square-and-multiply, exponent LSB first
                            if (stat.exp_zero)
                            begin
                                case (pow_reg)
                                    OP_LD_GK: step_next = OP_SAVE_R;
                                    OP_LD_GM: step_next = OP_SAVE_LHS;
                                    OP_LD_HR: step_next = OP_SAVE_RHS;
                                    default:  step_next = OP_MUL_FIN;
                                endcase
                            end
                            else if (stat.exp_lsb)
                                step_next = OP_MUL_ACC;
                            else
                                step_next = OP_SQR;
                        end
                        OP_MUL_ACC:  step_next = OP_SQR;
                        OP_SAVE_R:   step_next = OP_LD_EU;
                        OP_SAVE_LHS:
                        begin
                            step_next = OP_LD_HR;
                            pow_next  = OP_LD_HR;
                        end
                        OP_SAVE_RHS:
                        begin
                            step_next = OP_LD_RS;
                            pow_next  = OP_LD_RS;
                        end
                        OP_MUL_FIN:
                        begin
                            res_next   = RES_VER;
                            state_next = ST_OUT;
                        end
                        OP_LD_EU:    step_next = OP_RED_R1;
                        OP_RED_R1, OP_QT:
                        begin
                            // Euclid loop ends when the remainder hits zero
                            if (!stat.r1_zero)
                                step_next = OP_DIV;
                            else if (stat.r0_one)
                                step_next = OP_RED_D;
                            else
                            begin
                                res_next   = RES_NOINV;
                                state_next = ST_OUT;
                            end
                        end
                        OP_DIV:      step_next = OP_QT;
                        OP_RED_D:    step_next = OP_MUL_DR;
                        OP_MUL_DR:   step_next = OP_RED_M;
                        OP_RED_M:    step_next = OP_SUB;
                        OP_SUB:      step_next = OP_MUL_S;
                        default:
                        begin
                            res_next   = RES_SIGN;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and step registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= OP_LD_GK;
            pow_reg   <= OP_LD_GK;
            res_reg   <= RES_BADP;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pow_reg   <= pow_next;
            res_reg   <= res_next;
        end
    end

    // commands
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        cmd.take   = (state_reg == ST_IDLE) && in_valid;
        cmd.exec   = (state_reg == ST_ISSUE);
        cmd.op     = step_reg;
        cmd.finish = (state_reg == ST_OUT) && stat.out_free;
        cmd.res    = res_reg;
    end

endmodule

// File: design/elgamal_sign_verify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgamal_sign_verify: ElGamal signature sign/verify engine
// Signs a message with the configured key and nonce, or checks a signature
// against the configured public key; one result per item.
// ----------------------------------------------------------------------------
// channel   handshake               payload
// in        in_valid / in_stall     kind, message, check_r, check_s
// out       out_valid / out_stall   sig_r, sig_s, verified, no_inverse
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item at a time. Every modular multiply, reduction and division step
// runs on one bit-serial unit. A modular power takes one reduction and up
// to 2*WIDTH such operations, so a sign item runs one modular power plus
// the Euclid loop, and a verify item runs three modular powers.
// Asynchronous active-low reset restores the register defaults. A waiting
// result in the output register does not block the next item's accept.
// ----------------------------------------------------------------------------
module elgamal_sign_verify
    import esv_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [WIDTH-1:0]     message,
    input  logic [WIDTH-1:0]     check_r,
    input  logic [WIDTH-1:0]     check_s,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WIDTH-1:0]     sig_r,
    output logic [WIDTH-1:0]     sig_s,
    output logic                 verified,
    output logic                 no_inverse
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    esv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    esv_dpath #(.WIDTH(WIDTH)) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .message    (message),
        .check_r    (check_r),
        .check_s    (check_s),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .sig_r      (sig_r),
        .sig_s      (sig_s),
        .verified   (verified),
        .no_inverse (no_inverse),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule
